/* hw/rtl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition");

`endif

/* hw/rtl/dhc_pkg.sv */
// ----------------------------------------------------------------------------
// dhc_pkg
// types and constants of the depth histogram colorizer
// ----------------------------------------------------------------------------
package dhc_pkg;

	localparam int DEPTH_BITS      = 16;
	localparam int MAX_PIXELS_LOG2 = 20;
	localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
	localparam int TABLE_SIZE      = 1 << DEPTH_BITS;
	localparam int DATA_W          = 16;
	localparam int LEVEL_W         = 8;
	localparam int DIV_CNT_W       = $clog2(LEVEL_W);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_WALK_RD,
		ST_WALK_CALC,
		ST_WALK_DIV,
		ST_WALK_WR,
		ST_MAP_RD,
		ST_MAP_RES
	} state_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_INC,
		WR_CUM,
		WR_LVL,
		WR_ZERO
	} wr_kind_t;

	typedef enum logic {
		RD_PIX,
		RD_IDX
	} rd_sel_t;

	typedef struct packed {
		logic     capture;
		logic     rd_en;
		rd_sel_t  rd_sel;
		wr_kind_t wr_kind;
		logic     cnt_inc;
		logic     cnt_clr;
		logic     idx_clr;
		logic     idx_one;
		logic     idx_inc;
		logic     cum_clr;
		logic     cum_upd;
		logic     div_load;
		logic     div_step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic last;
		logic depth_zero;
		logic idx_end;
		logic div_done;
		logic cnt_zero;
		logic out_free;
	} stat_t;

endpackage

/* hw/rtl/dhc_ctrl.sv */
// ----------------------------------------------------------------------------
// dhc_ctrl
// sequencer for pixel handling, table walk and table clearing
// ----------------------------------------------------------------------------
module dhc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dhc_pkg::stat_t stat,
	output dhc_pkg::cmd_t  cmd
);

	dhc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.rd_sel  = dhc_pkg::RD_IDX;
		cmd.wr_kind = dhc_pkg::WR_NONE;
		in_ready    = 1'b0;
		unique case (state_q)
			dhc_pkg::ST_CLEAR: begin
				cmd.wr_kind = dhc_pkg::WR_ZERO;
				cmd.idx_inc = 1'b1;
				if (stat.idx_end) begin
					state_d = dhc_pkg::ST_IDLE;
				end
			end
			dhc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = dhc_pkg::ST_ACC_RD;
				end
			end
			dhc_pkg::ST_ACC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = dhc_pkg::RD_PIX;
				state_d    = stat.mode ? dhc_pkg::ST_MAP_RES : dhc_pkg::ST_ACC_WR;
			end
			dhc_pkg::ST_ACC_WR: begin
				if (!stat.depth_zero) begin
					cmd.wr_kind = dhc_pkg::WR_INC;
					cmd.cnt_inc = 1'b1;
				end
				if (stat.last) begin
					cmd.idx_one = 1'b1;
					cmd.cum_clr = 1'b1;
					state_d     = dhc_pkg::ST_WALK_RD;
				end else begin
					state_d = dhc_pkg::ST_IDLE;
				end
			end
			dhc_pkg::ST_WALK_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = dhc_pkg::ST_WALK_CALC;
			end
			dhc_pkg::ST_WALK_CALC: begin
				cmd.cum_upd = 1'b1;
				if (stat.cnt_zero) begin
					// empty frame keeps the running sums
					cmd.wr_kind = dhc_pkg::WR_CUM;
					cmd.idx_inc = 1'b1;
					state_d     = stat.idx_end ? dhc_pkg::ST_IDLE : dhc_pkg::ST_WALK_RD;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = dhc_pkg::ST_WALK_DIV;
				end
			end
			dhc_pkg::ST_WALK_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = dhc_pkg::ST_WALK_WR;
				end
			end
			dhc_pkg::ST_WALK_WR: begin
				cmd.wr_kind = dhc_pkg::WR_LVL;
				cmd.idx_inc = 1'b1;
				state_d     = stat.idx_end ? dhc_pkg::ST_IDLE : dhc_pkg::ST_WALK_RD;
			end
			dhc_pkg::ST_MAP_RD: begin
				// unused path kept for decode completeness
				state_d = dhc_pkg::ST_MAP_RES;
			end
			dhc_pkg::ST_MAP_RES: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.last) begin
						cmd.idx_clr = 1'b1;
						cmd.cnt_clr = 1'b1;
						state_d     = dhc_pkg::ST_CLEAR;
					end else begin
						state_d = dhc_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = dhc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/dhc_datapath.sv */
// ----------------------------------------------------------------------------
// dhc_datapath
// histogram table, pixel count, running sum, level divider, output word
// ----------------------------------------------------------------------------
module dhc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dhc_pkg::cmd_t                cmd,
	output dhc_pkg::stat_t               stat,
	input  logic                         in_mode,
	input  logic [dhc_pkg::DATA_W-1:0]   in_depth,
	input  logic                         in_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dhc_pkg::LEVEL_W-1:0]  out_level,
	output logic                         out_last
);

	logic [dhc_pkg::CNT_W-1:0]      table_mem [dhc_pkg::TABLE_SIZE];
	logic [dhc_pkg::CNT_W-1:0]      rd_q;
	logic                           mode_q;
	logic                           last_q;
	logic [dhc_pkg::DEPTH_BITS-1:0] depth_q;
	logic [dhc_pkg::DEPTH_BITS-1:0] idx_q;
	logic [dhc_pkg::CNT_W-1:0]      cnt_q;
	logic [dhc_pkg::CNT_W-1:0]      cum_q;
	logic [dhc_pkg::CNT_W-1:0]      rem_q;
	logic [dhc_pkg::LEVEL_W-1:0]    quo_q;
	logic [dhc_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic                           out_valid_q;
	logic [dhc_pkg::LEVEL_W-1:0]    out_level_q;
	logic                           out_last_q;

	logic [dhc_pkg::CNT_W:0]        cum_sum;
	logic [dhc_pkg::CNT_W-1:0]      cum_next;
	logic [dhc_pkg::CNT_W-1:0]      inc_val;
	logic [dhc_pkg::CNT_W:0]        rem_dbl;
	logic                           rem_ge;
	logic [dhc_pkg::DEPTH_BITS-1:0] rd_addr;
	logic [dhc_pkg::DEPTH_BITS-1:0] wr_addr;
	logic [dhc_pkg::CNT_W-1:0]      wr_data;

	assign cum_sum  = {1'b0, cum_q} + {1'b0, rd_q};
	assign cum_next = cum_sum[dhc_pkg::CNT_W] ? dhc_pkg::CNT_MAX
		: cum_sum[dhc_pkg::CNT_W-1:0];
	assign inc_val  = (rd_q == dhc_pkg::CNT_MAX) ? rd_q : rd_q + 1'b1;
	assign rem_dbl  = {rem_q, 1'b0};
	assign rem_ge   = rem_dbl >= {1'b0, cnt_q};
	assign rd_addr  = (cmd.rd_sel == dhc_pkg::RD_PIX) ? depth_q : idx_q;
	assign wr_addr  = (cmd.wr_kind == dhc_pkg::WR_INC) ? depth_q : idx_q;

	always_comb begin
		unique case (cmd.wr_kind)
			dhc_pkg::WR_INC: wr_data = inc_val;
			dhc_pkg::WR_CUM: wr_data = cum_next;
			dhc_pkg::WR_LVL: wr_data = {{(dhc_pkg::CNT_W-dhc_pkg::LEVEL_W){1'b0}}, quo_q};
			default:         wr_data = '0;
		endcase
	end

	// single port table, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_kind != dhc_pkg::WR_NONE) begin
			table_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= table_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= in_mode;
			last_q  <= in_last;
			depth_q <= in_depth[dhc_pkg::DEPTH_BITS-1:0];
		end
		if (cmd.cum_clr) begin
			cum_q <= '0;
		end else if (cmd.cum_upd) begin
			cum_q <= cum_next;
		end
		// fraction bits of (n - cum) / n; a whole quotient of one drops out
		if (cmd.div_load) begin
			rem_q <= (cum_next == '0 || cum_next >= cnt_q) ? '0 : cnt_q - cum_next;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? dhc_pkg::CNT_W'(rem_dbl - {1'b0, cnt_q})
				: rem_dbl[dhc_pkg::CNT_W-1:0];
			quo_q <= {quo_q[dhc_pkg::LEVEL_W-2:0], rem_ge};
		end
		if (cmd.out_load) begin
			out_level_q <= depth_q == '0 ? '0 : rd_q[dhc_pkg::LEVEL_W-1:0];
			out_last_q  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_one) begin
				idx_q <= dhc_pkg::DEPTH_BITS'(1);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc && cnt_q != dhc_pkg::CNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.div_load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.mode       = mode_q;
	assign stat.last       = last_q;
	assign stat.depth_zero = depth_q == '0;
	assign stat.idx_end    = &idx_q;
	assign stat.div_done   = &div_cnt_q;
	assign stat.cnt_zero   = cnt_q == '0;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_level = out_level_q;
	assign out_last  = out_last_q;

endmodule

/* hw/rtl/depth_histogram_colorizer.sv */
// Depth histogram colorizer. A frame goes in twice: accumulate words
// (tuser 0) build a histogram of nonzero depths, map words (tuser 1) each
// return one 8-bit level word. A new pixel is accepted only once the
// previous one is done, bound by the read-modify-write on the single port
// table. The last accumulate word starts a table walk over entries 1 to
// 65535 (each entry read, summed, divided bit by bit into the level and
// written back; the running sum is written back undivided when the frame
// had no nonzero depth). After reset and after the last map word all 65536
// table entries are zeroed. While walking or clearing, s_tready stays low.
// ----------------------------------------------------------------------------
// depth_histogram_colorizer
// top level: cumulative histogram depth to gray level mapping
// ----------------------------------------------------------------------------
module depth_histogram_colorizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] depth_sample
	input  logic [0:0]  s_tuser,  // [0] mode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] level
	output logic        m_tlast
);

	dhc_pkg::cmd_t  cmd;
	dhc_pkg::stat_t stat;

	dhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dhc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_mode   (s_tuser[0]),
		.in_depth  (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_level (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

/* hw/rtl/dhc_checker.sv */
// ----------------------------------------------------------------------------
// dhc_checker
// port level checks of the depth histogram colorizer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready
);

	// a stalled result word stays
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid)
	// one word at a time: busy right after an accept
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready)
	// a new result only comes out of a map word in progress
	`ASSERT_CLK(a_out_from_work, clk, arst_n, $rose(m_tvalid) |-> $past(!s_tready))

endmodule

bind depth_histogram_colorizer dhc_checker u_dhc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
